>>> rtl/pid_pkg.sv
// pid controller shared types, register indexes and default widths
package pid_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_IDX_W      = 3;

    // operating modes, the unused code behaves as passthrough
    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_POS  = 2'd1,
        MODE_INC  = 2'd2
    } t_mode;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 3'd0,
        REG_GAIN_P     = 3'd1,
        REG_GAIN_I     = 3'd2,
        REG_GAIN_D     = 3'd3,
        REG_OUT_LOW    = 3'd4,
        REG_OUT_HIGH   = 3'd5,
        REG_INTEG_LOW  = 3'd6,
        REG_INTEG_HIGH = 3'd7
    } t_cfg_reg;

endpackage

>>> rtl/pid_mult.sv
// registered fixed-point multiply with arithmetic shift and saturation
module pid_mult #(
    parameter int DATA_WIDTH = pid_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pid_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [DATA_WIDTH-1:0] i_a,
    input  logic signed [DATA_WIDTH-1:0] i_b,
    output logic signed [DATA_WIDTH-1:0] o_p
);

    localparam int PW = 2 * DATA_WIDTH;

    logic signed [PW-1:0]         prod;
    logic signed [PW-1:0]         shifted;
    logic        [DATA_WIDTH:0]   top_bits;
    logic signed [DATA_WIDTH-1:0] n_p;
    logic signed [DATA_WIDTH-1:0] r_p;

    assign prod     = i_a * i_b;
    assign shifted  = prod >>> FRAC_BITS;
    assign top_bits = shifted[PW-1:DATA_WIDTH-1];

    // saturate unless the upper bits are a pure sign extension
    always_comb begin
        if ((&top_bits) || !(|top_bits)) begin
            n_p = shifted[DATA_WIDTH-1:0];
        end else if (shifted[PW-1]) begin
            n_p = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            n_p = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

>>> rtl/pid_controller.sv
// pid controller top level: input stage, product stage and drive stage
// a result passes through the input stage, the product stage and the output register in turn
// throughput: one item per cycle while i_stall is low, set by the drive/integral update loop
// reset: synchronous, clears all controller state and valid flags, loads register defaults
// (positional mode, zero gains, widest clamps and anti-windup bounds)
module pid_controller #(
    parameter int DATA_WIDTH = pid_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pid_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // sample channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [DATA_WIDTH-1:0]     i_setpoint,
    input  logic signed [DATA_WIDTH-1:0]     i_feedback,
    // drive channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [DATA_WIDTH-1:0]     o_drive,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pid_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [DATA_WIDTH-1:0]            i_cfg_data
);

    localparam logic signed [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // saturating add and subtract on one guard bit
    function automatic logic signed [DATA_WIDTH-1:0] f_sat_add(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? VMIN : VMAX;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] f_sat_sub(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? VMIN : VMAX;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    // configuration registers
    logic [1:0]                   r_mode;
    logic signed [DATA_WIDTH-1:0] r_gain_p;
    logic signed [DATA_WIDTH-1:0] r_gain_i;
    logic signed [DATA_WIDTH-1:0] r_gain_d;
    logic signed [DATA_WIDTH-1:0] r_out_low;
    logic signed [DATA_WIDTH-1:0] r_out_high;
    logic signed [DATA_WIDTH-1:0] r_integ_low;
    logic signed [DATA_WIDTH-1:0] r_integ_high;

    // history of the sample stream, updated on each input transfer
    logic signed [DATA_WIDTH-1:0] r_last_fb;
    logic signed [DATA_WIDTH-1:0] r_last_err;
    logic signed [DATA_WIDTH-1:0] r_last_var;

    // controller state, updated as each drive value is formed
    logic signed [DATA_WIDTH-1:0] r_integral;
    logic signed [DATA_WIDTH-1:0] r_last_drive;

    // input stage
    logic                         r1_valid;
    logic signed [DATA_WIDTH-1:0] r1_sp;
    logic signed [DATA_WIDTH-1:0] r1_err;
    logic signed [DATA_WIDTH-1:0] r1_pterm;
    logic signed [DATA_WIDTH-1:0] r1_dterm;

    // product stage
    logic                         r2_valid;
    logic signed [DATA_WIDTH-1:0] r2_sp;
    logic signed [DATA_WIDTH-1:0] r2_err;
    logic signed [DATA_WIDTH-1:0] m_p;
    logic signed [DATA_WIDTH-1:0] m_i;
    logic signed [DATA_WIDTH-1:0] m_d;

    // output register
    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_drive;

    // flow control
    logic out_ready;
    logic s2_ready;
    logic s1_ready;
    logic in_xfer;
    logic s2_load;
    logic out_load;

    // front-end arithmetic
    logic signed [DATA_WIDTH-1:0] err;
    logic signed [DATA_WIDTH-1:0] var_fb;
    logic signed [DATA_WIDTH-1:0] d_err;
    logic signed [DATA_WIDTH-1:0] d_var;
    logic signed [DATA_WIDTH-1:0] n_pterm;
    logic signed [DATA_WIDTH-1:0] n_dterm;

    // drive stage arithmetic
    logic                         in_band;
    logic                         opposite;
    logic signed [DATA_WIDTH-1:0] integ_sum;
    logic signed [DATA_WIDTH-1:0] n_integral;
    logic signed [DATA_WIDTH-1:0] raw_drive;
    logic signed [DATA_WIDTH-1:0] n_drive;

    // each stage moves on when the one after it is empty or moving too
    assign out_ready = !r_out_valid || !i_stall;
    assign s2_ready  = !r2_valid || out_ready;
    assign s1_ready  = !r1_valid || s2_ready;
    assign in_xfer   = i_valid && s1_ready;
    assign s2_load   = s2_ready && r1_valid;
    assign out_load  = out_ready && r2_valid;

    assign o_stall     = !s1_ready;
    assign o_valid     = r_out_valid;
    assign o_drive     = r_drive;
    assign o_cfg_ready = 1'b1;

    // configuration writes, accepted every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= pid_pkg::MODE_POS;
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_out_low    <= VMIN;
            r_out_high   <= VMAX;
            r_integ_low  <= VMIN;
            r_integ_high <= VMAX;
        end else if (i_cfg_valid) begin
            case (pid_pkg::t_cfg_reg'(i_cfg_index))
                pid_pkg::REG_MODE:       r_mode       <= i_cfg_data[1:0];
                pid_pkg::REG_GAIN_P:     r_gain_p     <= i_cfg_data;
                pid_pkg::REG_GAIN_I:     r_gain_i     <= i_cfg_data;
                pid_pkg::REG_GAIN_D:     r_gain_d     <= i_cfg_data;
                pid_pkg::REG_OUT_LOW:    r_out_low    <= i_cfg_data;
                pid_pkg::REG_OUT_HIGH:   r_out_high   <= i_cfg_data;
                pid_pkg::REG_INTEG_LOW:  r_integ_low  <= i_cfg_data;
                pid_pkg::REG_INTEG_HIGH: r_integ_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // error, variation on measurement and their first differences;
    // these only depend on the sample stream, so they are formed ahead of the loop
    assign err    = f_sat_sub(i_setpoint, i_feedback);
    assign var_fb = f_sat_sub(r_last_fb, i_feedback);
    assign d_err  = f_sat_sub(err, r_last_err);
    assign d_var  = f_sat_sub(var_fb, r_last_var);

    // incremental mode multiplies the differences, positional mode the plain terms
    assign n_pterm = (r_mode == pid_pkg::MODE_INC) ? d_err : err;
    assign n_dterm = (r_mode == pid_pkg::MODE_INC) ? d_var : var_fb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid   <= 1'b0;
            r_last_fb  <= '0;
            r_last_err <= '0;
            r_last_var <= '0;
        end else begin
            if (s1_ready) begin
                r1_valid <= i_valid;
            end
            if (in_xfer) begin
                r_last_fb  <= i_feedback;
                r_last_err <= err;
                r_last_var <= var_fb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r1_sp    <= i_setpoint;
            r1_err   <= err;
            r1_pterm <= n_pterm;
            r1_dterm <= n_dterm;
        end
    end

    // three gain products in parallel, registered inside each unit
    pid_mult #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mult_p (
        .i_clk (i_clk),
        .i_en  (s2_load),
        .i_a   (r_gain_p),
        .i_b   (r1_pterm),
        .o_p   (m_p)
    );

    pid_mult #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mult_i (
        .i_clk (i_clk),
        .i_en  (s2_load),
        .i_a   (r_gain_i),
        .i_b   (r1_err),
        .o_p   (m_i)
    );

    pid_mult #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mult_d (
        .i_clk (i_clk),
        .i_en  (s2_load),
        .i_a   (r_gain_d),
        .i_b   (r1_dterm),
        .o_p   (m_d)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_ready) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r2_sp  <= r1_sp;
            r2_err <= r1_err;
        end
    end

    // anti-windup: integrate while strictly inside the bounds,
    // or when the error pulls the integral back towards zero
    assign in_band   = (r_integral > r_integ_low) && (r_integral < r_integ_high);
    assign opposite  = ((r_integral < 0) && (r2_err > 0)) ||
                       ((r_integral > 0) && (r2_err < 0));
    assign integ_sum = f_sat_add(r_integral, m_i);

    // drive value, sums saturate left to right
    always_comb begin
        n_integral = r_integral;
        case (r_mode)
            pid_pkg::MODE_POS: begin
                if (in_band || opposite) begin
                    n_integral = integ_sum;
                end
                raw_drive = f_sat_add(f_sat_add(m_p, n_integral), m_d);
            end
            pid_pkg::MODE_INC: begin
                raw_drive = f_sat_add(f_sat_add(f_sat_add(r_last_drive, m_p), m_i), m_d);
            end
            default: begin
                // passthrough, the unused code included
                raw_drive = r2_sp;
            end
        endcase
    end

    // output clamp; when the bounds cross, the lower bound wins below it and the upper bound otherwise
    always_comb begin
        if (raw_drive < r_out_low) begin
            n_drive = r_out_low;
        end else if (raw_drive > r_out_high) begin
            n_drive = r_out_high;
        end else begin
            n_drive = raw_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_integral   <= '0;
            r_last_drive <= '0;
        end else begin
            if (out_ready) begin
                r_out_valid <= r2_valid;
            end
            if (out_load) begin
                r_integral   <= n_integral;
                r_last_drive <= n_drive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_drive <= n_drive;
        end
    end

endmodule
